// ===== sv/umc_pkg.sv =====
// ----------------------------------------------------------------------------
// umc_pkg
// Shared types and constants for the motor command controller.
// ----------------------------------------------------------------------------
package umc_pkg;

    localparam int PERIOD_W    = 20;
    localparam int THRESH_W    = 10;
    localparam int INTERVAL_W  = 6;
    localparam int CFG_DATA_W  = 20;
    localparam int CFG_INDEX_W = 2;
    localparam int SPEED_W     = 7;
    localparam int DIST_W      = 10;

    // period * speed, with speed at most 100
    localparam int PROD_W      = PERIOD_W + SPEED_W;
    // floor(x / 100) == (x * RECIP) >> RECIP_SHIFT for every x below 2**PROD_W
    localparam int RECIP_W     = 28;
    localparam int RECIP_SHIFT = 34;
    localparam logic [RECIP_W-1:0] RECIP = 28'd171798692;
    localparam int MUL_W       = PROD_W + RECIP_W;

    localparam logic [SPEED_W-1:0] SPEED_MAX = 7'd100;

    localparam logic [PERIOD_W-1:0]   PERIOD_RESET   = 20'd120000;
    localparam logic [THRESH_W-1:0]   THRESH_RESET   = 10'd3;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 6'd20;

    localparam logic [CFG_INDEX_W-1:0] REG_PWM_PERIOD   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OBSTACLE     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TELEMETRY    = 2'd2;

    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_NUL  = 8'h00;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_A    = 8'h41;
    localparam logic [7:0] CHAR_B    = 8'h42;
    localparam logic [7:0] CHAR_S    = 8'h53;

    localparam logic [3:0] KW_LEN      = 4'd6;
    localparam logic [3:0] KW_MISMATCH = 4'd15;

    // Completed-line command handed from the parser to the control logic
    typedef struct packed {
        logic               done;
        logic               buzzer;
        logic [7:0]         lead;
        logic [SPEED_W-1:0] value;
    } line_t;

    // Characters of the "buzzer" keyword
    function automatic logic [7:0] kw_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h62; // b
            3'd1:    ch = 8'h75; // u
            3'd2:    ch = 8'h7A; // z
            3'd3:    ch = 8'h7A; // z
            3'd4:    ch = 8'h65; // e
            3'd5:    ch = 8'h72; // r
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== sv/umc_line_parser.sv =====
// ----------------------------------------------------------------------------
// umc_line_parser
// Collects UART bytes into a line: leading character, saturated decimal
// value and keyword match; flags the line end.
// ----------------------------------------------------------------------------
module umc_line_parser #(
    parameter int LINE_CAPACITY = 19
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  logic                 byte_valid,
    input  logic [7:0]           rx_byte,
    output umc_pkg::line_t       line
);

    localparam int LEN_W = $clog2(LINE_CAPACITY + 1);
    localparam logic [LEN_W-1:0] CAP = LEN_W'(LINE_CAPACITY);

    logic [LEN_W-1:0]            len_reg, len_next;
    logic [7:0]                  lead_reg, lead_next;
    logic [umc_pkg::SPEED_W-1:0] acc_reg, acc_next;
    logic [3:0]                  kw_reg, kw_next;
    logic                        nul_reg, nul_next;
    logic                        is_eol;
    logic                        is_digit;
    logic [9:0]                  acc_sum;

    assign is_eol   = (rx_byte == umc_pkg::CHAR_LF) || (rx_byte == umc_pkg::CHAR_CR);
    assign is_digit = (rx_byte >= umc_pkg::CHAR_ZERO) && (rx_byte <= umc_pkg::CHAR_NINE);
    assign acc_sum  = 10'(acc_reg) * 10'd10 + {6'b0, rx_byte[3:0]};

    assign line.done   = fire && byte_valid && is_eol;
    assign line.buzzer = (kw_reg == umc_pkg::KW_LEN);
    assign line.lead   = lead_reg;
    assign line.value  = acc_reg;

    always_comb
    begin
        len_next  = len_reg;
        lead_next = lead_reg;
        acc_next  = acc_reg;
        kw_next   = kw_reg;
        nul_next  = nul_reg;
        if (fire && byte_valid)
        begin
            if (is_eol)
            begin
                len_next  = '0;
                lead_next = '0;
                acc_next  = '0;
                kw_next   = '0;
                nul_next  = 1'b0;
            end
            else if (len_reg < CAP)
            begin
                if (!nul_reg)
                begin
                    if (len_reg == '0)
                    begin
                        lead_next = rx_byte;
                    end
                    if (rx_byte == umc_pkg::CHAR_NUL)
                    begin
                        nul_next = 1'b1;
                    end
                    else
                    begin
                        if ((kw_reg < umc_pkg::KW_LEN)
                            && (rx_byte == umc_pkg::kw_char(kw_reg[2:0])))
                        begin
                            kw_next = kw_reg + 4'd1;
                        end
                        else
                        begin
                            kw_next = umc_pkg::KW_MISMATCH;
                        end
                        if ((len_reg != '0) && is_digit)
                        begin
                            // saturate at full speed
                            acc_next = (acc_sum > 10'(umc_pkg::SPEED_MAX))
                                     ? umc_pkg::SPEED_MAX : acc_sum[6:0];
                        end
                    end
                end
                len_next = len_reg + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            lead_reg <= '0;
            acc_reg  <= '0;
            kw_reg   <= '0;
            nul_reg  <= 1'b0;
        end
        else
        begin
            len_reg  <= len_next;
            lead_reg <= lead_next;
            acc_reg  <= acc_next;
            kw_reg   <= kw_next;
            nul_reg  <= nul_next;
        end
    end

endmodule

// ===== sv/umc_pwm_width.sv =====
// ----------------------------------------------------------------------------
// umc_pwm_width
// Keeps period * speed registered alongside the speed and turns it into
// a PWM width: product / 100 by reciprocal multiply, at least 1.
// ----------------------------------------------------------------------------
module umc_pwm_width (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [umc_pkg::PERIOD_W-1:0]  period,
    input  logic [umc_pkg::SPEED_W-1:0]   speed_next,
    output logic [umc_pkg::PERIOD_W-1:0]  width
);

    logic [umc_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic [umc_pkg::MUL_W-1:0]    scaled;
    logic [umc_pkg::PERIOD_W-1:0] quot;

    // track the speed register's next value so the product matches it
    assign prod_next = umc_pkg::PROD_W'(period) * umc_pkg::PROD_W'(speed_next);

    assign scaled = umc_pkg::MUL_W'(prod_reg) * umc_pkg::MUL_W'(umc_pkg::RECIP);
    assign quot   = scaled[umc_pkg::RECIP_SHIFT +: umc_pkg::PERIOD_W];
    assign width  = (quot == '0) ? umc_pkg::PERIOD_W'(1) : quot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg <= '0;
        end
        else
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

// ===== sv/uart_motor_command_controller.sv =====
// An accepted item lands in the input register; its result then moves into the
// result register, which drives out_valid, as soon as that register can take it.
// Throughput: one item per cycle while the sink does not stall; while the sink holds
// a result, the input register can still take one, stalling only when both are full.
// Reset: speeds, line state and counters clear, buttons read as released, and
// the registers return to period 120000, threshold 3, interval 20.
// ----------------------------------------------------------------------------
// uart_motor_command_controller
// Per-tick motor control: PWM widths, obstacle stop, button reports,
// telemetry timing and UART line commands.
// ----------------------------------------------------------------------------
module uart_motor_command_controller #(
    parameter int LINE_CAPACITY = 19
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             cfg_write_enable,
    input  logic [umc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [umc_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             button_one_level,
    input  logic                             button_two_level,
    input  logic [umc_pkg::DIST_W-1:0]       distance_cm,
    input  logic                             byte_valid,
    input  logic [7:0]                       rx_byte,

    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [umc_pkg::PERIOD_W-1:0]     width_one,
    output logic [umc_pkg::PERIOD_W-1:0]     width_two,
    output logic                             stop_report,
    output logic                             motor_one_report,
    output logic                             motor_two_report,
    output logic                             telemetry_valid,
    output logic [umc_pkg::DIST_W-1:0]       telemetry_distance,
    output logic                             buzzer_pulse
);

    // configuration
    logic [umc_pkg::PERIOD_W-1:0]   period_reg;
    logic [umc_pkg::PERIOD_W-1:0]   period_next;
    logic [umc_pkg::THRESH_W-1:0]   thresh_reg;
    logic [umc_pkg::INTERVAL_W-1:0] interval_reg;

    // input register
    logic                           in_valid_reg;
    logic                           b1_in_reg, b2_in_reg, bv_in_reg;
    logic [umc_pkg::DIST_W-1:0]     dist_in_reg;
    logic [7:0]                     byte_in_reg;

    // tick state
    logic [umc_pkg::SPEED_W-1:0]    speed_one_reg, speed_one_next;
    logic [umc_pkg::SPEED_W-1:0]    speed_two_reg, speed_two_next;
    logic                           moving_reg, moving_next;
    logic                           last_b1_reg, last_b2_reg;
    logic [umc_pkg::INTERVAL_W-1:0] tick_reg, tick_next, tick_inc;

    // result register
    logic                           out_valid_reg;
    logic [umc_pkg::PERIOD_W-1:0]   w1_out_reg, w2_out_reg;
    logic                           stop_out_reg, m1_out_reg, m2_out_reg;
    logic                           tv_out_reg, buzz_out_reg;
    logic [umc_pkg::DIST_W-1:0]     td_out_reg;

    logic                           accept;
    logic                           advance;
    logic                           obstacle;
    logic                           m1, m2, stop, tv;
    logic [umc_pkg::PERIOD_W-1:0]   w1_raw, w2_raw;
    umc_pkg::line_t                 line;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    // the width units register the product, so hand them the period as it
    // stands after this edge
    assign period_next = (cfg_write_enable && (cfg_index == umc_pkg::REG_PWM_PERIOD))
                       ? cfg_data[umc_pkg::PERIOD_W-1:0] : period_reg;

    umc_line_parser #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (advance),
        .byte_valid (bv_in_reg),
        .rx_byte    (byte_in_reg),
        .line       (line)
    );

    umc_pwm_width u_width_one (
        .clk        (clk),
        .rst_n      (rst_n),
        .period     (period_next),
        .speed_next (speed_one_next),
        .width      (w1_raw)
    );

    umc_pwm_width u_width_two (
        .clk        (clk),
        .rst_n      (rst_n),
        .period     (period_next),
        .speed_next (speed_two_next),
        .width      (w2_raw)
    );

    assign obstacle = dist_in_reg <= thresh_reg;
    assign m1       = !obstacle && !b1_in_reg && last_b1_reg;
    assign m2       = !obstacle && !b2_in_reg && last_b2_reg;
    assign stop     = obstacle && moving_reg;
    assign tick_inc = tick_reg + umc_pkg::INTERVAL_W'(1);
    assign tv       = tick_inc >= interval_reg;

    always_comb
    begin
        speed_one_next = speed_one_reg;
        speed_two_next = speed_two_reg;
        moving_next    = moving_reg;
        tick_next      = tick_reg;
        if (advance)
        begin
            tick_next = tv ? '0 : tick_inc;
            if (obstacle)
            begin
                speed_one_next = '0;
                speed_two_next = '0;
                moving_next    = 1'b0;
            end
            else if (m1 || m2)
            begin
                moving_next = 1'b1;
            end
            // the line command acts after the obstacle check
            if (line.done && !line.buzzer)
            begin
                case (line.lead)
                    umc_pkg::CHAR_A:
                    begin
                        speed_one_next = line.value;
                        speed_two_next = '0;
                    end
                    umc_pkg::CHAR_B:
                    begin
                        speed_one_next = '0;
                        speed_two_next = line.value;
                    end
                    umc_pkg::CHAR_S:
                    begin
                        speed_one_next = line.value;
                        speed_two_next = line.value;
                    end
                    default:
                    begin
                        speed_one_next = speed_one_next;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg   <= umc_pkg::PERIOD_RESET;
            thresh_reg   <= umc_pkg::THRESH_RESET;
            interval_reg <= umc_pkg::INTERVAL_RESET;
        end
        else if (cfg_write_enable)
        begin
            case (cfg_index)
                umc_pkg::REG_PWM_PERIOD: period_reg   <= cfg_data[umc_pkg::PERIOD_W-1:0];
                umc_pkg::REG_OBSTACLE:   thresh_reg   <= cfg_data[umc_pkg::THRESH_W-1:0];
                umc_pkg::REG_TELEMETRY:  interval_reg <= cfg_data[umc_pkg::INTERVAL_W-1:0];
                default:                 period_reg   <= period_reg;
            endcase
        end
    end

    // input register: hold while the result register is full and stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b1_in_reg   <= button_one_level;
            b2_in_reg   <= button_two_level;
            dist_in_reg <= distance_cm;
            bv_in_reg   <= byte_valid;
            byte_in_reg <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_one_reg <= '0;
            speed_two_reg <= '0;
            moving_reg    <= 1'b0;
            last_b1_reg   <= 1'b1;
            last_b2_reg   <= 1'b1;
            tick_reg      <= '0;
        end
        else
        begin
            speed_one_reg <= speed_one_next;
            speed_two_reg <= speed_two_next;
            moving_reg    <= moving_next;
            tick_reg      <= tick_next;
            if (advance)
            begin
                last_b1_reg <= b1_in_reg;
                last_b2_reg <= b2_in_reg;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            w1_out_reg   <= obstacle ? umc_pkg::PERIOD_W'(1) : w1_raw;
            w2_out_reg   <= obstacle ? umc_pkg::PERIOD_W'(1) : w2_raw;
            stop_out_reg <= stop;
            m1_out_reg   <= m1;
            m2_out_reg   <= m2;
            tv_out_reg   <= tv;
            td_out_reg   <= tv ? dist_in_reg : '0;
            buzz_out_reg <= line.done && line.buzzer;
        end
    end

    assign out_valid          = out_valid_reg;
    assign width_one          = w1_out_reg;
    assign width_two          = w2_out_reg;
    assign stop_report        = stop_out_reg;
    assign motor_one_report   = m1_out_reg;
    assign motor_two_report   = m2_out_reg;
    assign telemetry_valid    = tv_out_reg;
    assign telemetry_distance = td_out_reg;
    assign buzzer_pulse       = buzz_out_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while the result register could drain");

    a_stop_forces_min_width: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && stop_report) |-> (width_one == 20'd1 && width_two == 20'd1))
        else $error("stop reported without minimum widths");

    a_stop_excludes_buttons: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && stop_report) |-> (!motor_one_report && !motor_two_report))
        else $error("button event reported during an obstacle stop");

    a_telemetry_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !telemetry_valid) |-> (telemetry_distance == '0))
        else $error("telemetry distance set without a report");

    a_stop_clears_speeds: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && obstacle && !line.done) |=> (speed_one_reg == '0 && speed_two_reg == '0))
        else $error("speeds not cleared by an obstacle");

endmodule

// ===== tb/sv/uart_motor_command_controller_test.sv =====
// ----------------------------------------------------------------------------
// uart_motor_command_controller_test
// Drives control ticks (buttons, distance, UART bytes) into the motor command
// controller. A scoreboard class predicts each tick's widths, reports,
// telemetry and buzzer flag, then checks every result beat against it.
// ----------------------------------------------------------------------------
module uart_motor_command_controller_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_CAPACITY = 19;
    localparam int CYCLE_LIMIT   = 250000;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [umc_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic                       button_one;
        logic                       button_two;
        logic [umc_pkg::DIST_W-1:0] distance;
        logic                       byte_valid;
        logic [7:0]                 rx_byte;
    } tick_in_t;

    typedef struct packed {
        logic [umc_pkg::PERIOD_W-1:0] width_one;
        logic [umc_pkg::PERIOD_W-1:0] width_two;
        logic                         stop_report;
        logic                         motor_one_report;
        logic                         motor_two_report;
        logic                         telemetry_valid;
        logic [umc_pkg::DIST_W-1:0]   telemetry_distance;
        logic                         buzzer_pulse;
    } tick_out_t;

    // Tracks controller state per tick and holds the outputs still owed
    class motor_tick_tracker;
        logic [umc_pkg::PERIOD_W-1:0]   period;
        logic [umc_pkg::THRESH_W-1:0]   threshold;
        logic [umc_pkg::INTERVAL_W-1:0] interval;
        logic [umc_pkg::SPEED_W-1:0]    speed_one;
        logic [umc_pkg::SPEED_W-1:0]    speed_two;
        logic                           moving;
        logic                           last_one;
        logic                           last_two;
        int                             line_len;
        logic [7:0]                     lead;
        logic [umc_pkg::SPEED_W-1:0]    digits;
        logic [3:0]                     kw_pos;
        logic                           nul_seen;
        logic [umc_pkg::INTERVAL_W-1:0] tick_count;
        int                             capacity;
        string                          keyword;
        int                             mismatches;
        tick_out_t                      outputs_due[$];

        function new(int line_capacity);
            capacity   = line_capacity;
            keyword    = "buzzer";
            mismatches = 0;
            power_on();
        endfunction

        function void clear_line();
            line_len = 0;
            lead     = '0;
            digits   = '0;
            kw_pos   = '0;
            nul_seen = 1'b0;
        endfunction

        function void power_on();
            period     = umc_pkg::PERIOD_RESET;
            threshold  = umc_pkg::THRESH_RESET;
            interval   = umc_pkg::INTERVAL_RESET;
            speed_one  = '0;
            speed_two  = '0;
            moving     = 1'b0;
            last_one   = 1'b1;
            last_two   = 1'b1;
            tick_count = '0;
            clear_line();
        endfunction

        function void set_register(logic [umc_pkg::CFG_INDEX_W-1:0] idx,
                                   logic [umc_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                umc_pkg::REG_PWM_PERIOD: period    = data[umc_pkg::PERIOD_W-1:0];
                umc_pkg::REG_OBSTACLE:   threshold = data[umc_pkg::THRESH_W-1:0];
                umc_pkg::REG_TELEMETRY:  interval  = data[umc_pkg::INTERVAL_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [umc_pkg::PERIOD_W-1:0] width_for(logic [umc_pkg::SPEED_W-1:0] speed);
            logic [63:0] w;
            w = (64'(period) * 64'(speed)) / 64'd100;
            if (w == 64'd0)
            begin
                w = 64'd1;
            end
            return w[umc_pkg::PERIOD_W-1:0];
        endfunction

        function void take_tick(tick_in_t t);
            tick_out_t  r;
            logic [7:0] c;
            int         v;
            r = '0;
            c = t.rx_byte;

            tick_count = tick_count + 1'b1;
            if (tick_count >= interval)
            begin
                r.telemetry_valid    = 1'b1;
                r.telemetry_distance = t.distance;
                tick_count           = '0;
            end

            // widths come from the speeds held before this tick's byte
            r.width_one = width_for(speed_one);
            r.width_two = width_for(speed_two);

            if (t.distance <= threshold)
            begin
                r.width_one = umc_pkg::PERIOD_W'(1);
                r.width_two = umc_pkg::PERIOD_W'(1);
                speed_one   = '0;
                speed_two   = '0;
                if (moving)
                begin
                    r.stop_report = 1'b1;
                    moving        = 1'b0;
                end
            end
            else
            begin
                if (!t.button_one && last_one)
                begin
                    r.motor_one_report = 1'b1;
                    moving             = 1'b1;
                end
                if (!t.button_two && last_two)
                begin
                    r.motor_two_report = 1'b1;
                    moving             = 1'b1;
                end
            end
            last_one = t.button_one;
            last_two = t.button_two;

            if (t.byte_valid)
            begin
                if (c == umc_pkg::CHAR_LF || c == umc_pkg::CHAR_CR)
                begin
                    if (kw_pos == umc_pkg::KW_LEN)
                        r.buzzer_pulse = 1'b1;
                    else if (lead == umc_pkg::CHAR_A)
                    begin
                        speed_one = digits;
                        speed_two = '0;
                    end
                    else if (lead == umc_pkg::CHAR_B)
                    begin
                        speed_two = digits;
                        speed_one = '0;
                    end
                    else if (lead == umc_pkg::CHAR_S)
                    begin
                        speed_one = digits;
                        speed_two = digits;
                    end
                    clear_line();
                end
                else if (line_len < capacity)
                begin
                    if (!nul_seen)
                    begin
                        if (line_len == 0)
                            lead = c;
                        if (c == umc_pkg::CHAR_NUL)
                            nul_seen = 1'b1;
                        else
                        begin
                            if (kw_pos < umc_pkg::KW_LEN && c == 8'(keyword[kw_pos]))
                                kw_pos = kw_pos + 1'b1;
                            else
                                kw_pos = umc_pkg::KW_MISMATCH;
                            if (line_len >= 1 && c >= umc_pkg::CHAR_ZERO
                                && c <= umc_pkg::CHAR_NINE)
                            begin
                                v      = int'(digits) * 10 + int'(c - umc_pkg::CHAR_ZERO);
                                digits = (v > 100) ? umc_pkg::SPEED_MAX
                                                   : v[umc_pkg::SPEED_W-1:0];
                            end
                        end
                    end
                    line_len++;
                end
            end

            outputs_due.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void match_tick(tick_out_t got);
            tick_out_t want;
            if (outputs_due.size() == 0)
            begin
                $error("result beat with no tick outstanding");
                mismatches++;
                return;
            end
            want = outputs_due.pop_front();
            compare_field("width_one", want.width_one, got.width_one);
            compare_field("width_two", want.width_two, got.width_two);
            compare_field("stop_report", want.stop_report, got.stop_report);
            compare_field("motor_one_report", want.motor_one_report, got.motor_one_report);
            compare_field("motor_two_report", want.motor_two_report, got.motor_two_report);
            compare_field("telemetry_valid", want.telemetry_valid, got.telemetry_valid);
            compare_field("telemetry_distance", want.telemetry_distance,
                          got.telemetry_distance);
            compare_field("buzzer_pulse", want.buzzer_pulse, got.buzzer_pulse);
        endfunction

        function int pending();
            return outputs_due.size();
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_write_enable;
    logic [umc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [umc_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                            in_valid;
    logic                            in_stall;
    logic                            button_one_level;
    logic                            button_two_level;
    logic [umc_pkg::DIST_W-1:0]      distance_cm;
    logic                            byte_valid;
    logic [7:0]                      rx_byte;
    logic                            out_valid;
    logic                            out_stall;
    logic [umc_pkg::PERIOD_W-1:0]    width_one;
    logic [umc_pkg::PERIOD_W-1:0]    width_two;
    logic                            stop_report;
    logic                            motor_one_report;
    logic                            motor_two_report;
    logic                            telemetry_valid;
    logic [umc_pkg::DIST_W-1:0]      telemetry_distance;
    logic                            buzzer_pulse;

    motor_tick_tracker tracker;
    int                cycle_count = 0;
    int                ticks_sent  = 0;
    int                burst_left  = 0;
    int unsigned       stall_mode  = 0;
    int unsigned       stall_left  = 0;
    int unsigned       stall_tick  = 0;
    logic              held_one    = 1'b1;
    logic              held_two    = 1'b1;
    logic [7:0]        line_buf[$];

    uart_motor_command_controller #(
        .LINE_CAPACITY(LINE_CAPACITY)
    ) dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write_enable  (cfg_write_enable),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .button_one_level  (button_one_level),
        .button_two_level  (button_two_level),
        .distance_cm       (distance_cm),
        .byte_valid        (byte_valid),
        .rx_byte           (rx_byte),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .width_one         (width_one),
        .width_two         (width_two),
        .stop_report       (stop_report),
        .motor_one_report  (motor_one_report),
        .motor_two_report  (motor_two_report),
        .telemetry_valid   (telemetry_valid),
        .telemetry_distance(telemetry_distance),
        .buzzer_pulse      (buzzer_pulse)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[uart_motor_command_controller] ERROR");
            $finish;
        end
    end

    // Receiver stall: switch between randomly chosen pattern modes
    initial out_stall = 1'b0;
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            0:       out_stall = 1'b0;
            1:       out_stall = ($urandom_range(0, 7) == 0);
            2:       out_stall = ($urandom_range(0, 3) != 0);
            default: out_stall = ((stall_tick % 7) < 3);
        endcase
    end

    always @(posedge clk)
    begin
        tick_out_t got;
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            got.width_one          = width_one;
            got.width_two          = width_two;
            got.stop_report        = stop_report;
            got.motor_one_report   = motor_one_report;
            got.motor_two_report   = motor_two_report;
            got.telemetry_valid    = telemetry_valid;
            got.telemetry_distance = telemetry_distance;
            got.buzzer_pulse       = buzzer_pulse;
            tracker.match_tick(got);
        end
    end

    task automatic send_tick(input tick_in_t t);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid         = 1'b1;
        button_one_level = t.button_one;
        button_two_level = t.button_two;
        distance_cm      = t.distance;
        byte_valid       = t.byte_valid;
        rx_byte          = t.rx_byte;
        do @(posedge clk); while (in_stall);
        tracker.take_tick(t);
        ticks_sent++;
    endtask

    task automatic tick(input logic b1, input logic b2,
                        input logic [umc_pkg::DIST_W-1:0] dist_cm,
                        input logic bv, input logic [7:0] c);
        tick_in_t t;
        t.button_one = b1;
        t.button_two = b2;
        t.distance   = dist_cm;
        t.byte_valid = bv;
        t.rx_byte    = c;
        send_tick(t);
    endtask

    task automatic type_line(input string s, input logic [7:0] term,
                             input logic [umc_pkg::DIST_W-1:0] dist_cm);
        for (int i = 0; i < s.len(); i++)
            tick(1'b1, 1'b1, dist_cm, 1'b1, 8'(s[i]));
        tick(1'b1, 1'b1, dist_cm, 1'b1, term);
    endtask

    task automatic write_register(input logic [umc_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [umc_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write_enable = 1'b1;
        cfg_index        = idx;
        cfg_data         = data;
        @(negedge clk);
        cfg_write_enable = 1'b0;
        tracker.set_register(idx, data);
    endtask

    // Hold the sender until every owed result has come back, then let it settle
    task automatic finish_phase();
        @(negedge clk);
        in_valid = 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [umc_pkg::DIST_W-1:0] pick_distance();
        int th;
        int d;
        th = int'(tracker.threshold);
        case ($urandom_range(0, 9))
            0:       d = th + $urandom_range(0, 2) - 1;
            1:       d = 999;
            2:       d = ($urandom_range(0, 1) == 0) ? 0 : 1023;
            3:       d = th;
            4, 5:    d = $urandom_range(0, 1023);
            default: d = (th >= 1023) ? 1023 : $urandom_range(th + 1, 1023);
        endcase
        if (d < 0)
            d = 0;
        if (d > 1023)
            d = 1023;
        return d[umc_pkg::DIST_W-1:0];
    endfunction

    task automatic random_tick(input logic bv, input logic [7:0] c);
        if ($urandom_range(0, 2) == 0)
            held_one = ~held_one;
        if ($urandom_range(0, 2) == 0)
            held_two = ~held_two;
        tick(held_one, held_two, pick_distance(), bv, c);
    endtask

    function automatic logic [7:0] pick_lead();
        case ($urandom_range(0, 2))
            0:       return umc_pkg::CHAR_A;
            1:       return umc_pkg::CHAR_B;
            default: return umc_pkg::CHAR_S;
        endcase
    endfunction

    function automatic logic [7:0] pick_digit();
        return umc_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
    endfunction

    task automatic compose_line();
        int n;
        int k;
        line_buf.delete();
        case ($urandom_range(0, 11))
            0, 1, 2, 3:
            begin
                line_buf.push_back(pick_lead());
                n = $urandom_range(0, 4);
                for (int i = 0; i < n; i++)
                begin
                    if ($urandom_range(0, 7) == 0)
                        line_buf.push_back(8'($urandom_range(32, 126)));
                    else
                        line_buf.push_back(pick_digit());
                end
            end
            4:
                for (int i = 0; i < tracker.keyword.len(); i++)
                    line_buf.push_back(8'(tracker.keyword[i]));
            5:
            begin
                for (int i = 0; i < tracker.keyword.len(); i++)
                    line_buf.push_back(8'(tracker.keyword[i]));
                k = $urandom_range(0, 2);
                if (k == 0)
                begin
                    n = $urandom_range(0, 5);
                    line_buf[n] = line_buf[n] ^ 8'h01;
                end
                else if (k == 1)
                    line_buf.push_back(8'($urandom_range(32, 126)));
                else
                    void'(line_buf.pop_back());
            end
            6:
            begin
                // can run past the line capacity
                line_buf.push_back(pick_lead());
                n = $urandom_range(16, 26);
                for (int i = 0; i < n; i++)
                    line_buf.push_back(($urandom_range(0, 3) == 0) ? pick_digit()
                                                                   : umc_pkg::CHAR_ZERO);
            end
            7:
            begin
                line_buf.push_back(pick_lead());
                n = $urandom_range(0, 2);
                for (int i = 0; i < n; i++)
                    line_buf.push_back(pick_digit());
                line_buf.push_back(umc_pkg::CHAR_NUL);
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    line_buf.push_back(pick_digit());
            end
            8, 9:
            begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                    line_buf.push_back(8'($urandom_range(0, 255)));
            end
            10: ;
            default:
            begin
                line_buf.push_back(8'($urandom_range(0, 255)));
                line_buf.push_back(pick_digit());
            end
        endcase
        line_buf.push_back(($urandom_range(0, 1) == 0) ? umc_pkg::CHAR_LF : umc_pkg::CHAR_CR);
    endtask

    task automatic run_random(input int count);
        int target;
        target = ticks_sent + count;
        while (ticks_sent < target)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                repeat ($urandom_range(1, 6))
                    random_tick(1'b0, 8'($urandom_range(0, 255)));
            end
            else
            begin
                compose_line();
                foreach (line_buf[i])
                begin
                    if ($urandom_range(0, 3) == 0)
                        random_tick(1'b0, 8'($urandom_range(0, 255)));
                    random_tick(1'b1, line_buf[i]);
                end
            end
        end
    endtask

    task automatic random_config();
        logic [umc_pkg::PERIOD_W-1:0]   period;
        logic [umc_pkg::THRESH_W-1:0]   thr;
        case ($urandom_range(0, 5))
            0:       period = 20'd1;
            1:       period = 20'd100;
            2:       period = 20'd120000;
            3:       period = 20'hFFFFF;
            4:       period = 20'($urandom_range(1, 1000));
            default: period = 20'($urandom_range(1, 1048575));
        endcase
        case ($urandom_range(0, 7))
            0:       thr = 10'($urandom_range(0, 1023));
            default: thr = 10'($urandom_range(0, 30));
        endcase
        write_register(umc_pkg::REG_PWM_PERIOD, period);
        // upper data bits past a register's width are junk
        write_register(umc_pkg::REG_OBSTACLE, {10'($urandom), thr});
        write_register(umc_pkg::REG_TELEMETRY, {14'($urandom), 6'($urandom_range(0, 63))});
    endtask

    initial
    begin
        tracker          = new(LINE_CAPACITY);
        rst_n            = 1'b0;
        cfg_write_enable = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        in_valid         = 1'b0;
        button_one_level = 1'b1;
        button_two_level = 1'b1;
        distance_cm      = '0;
        byte_valid       = 1'b0;
        rx_byte          = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: button edges, obstacle at threshold, A, B, buzzer, empty and unknown lines
        tick(1'b1, 1'b1, 10'd1023, 1'b0, 8'hFF);
        tick(1'b0, 1'b1, 10'd500, 1'b0, 8'h00);
        tick(1'b0, 1'b0, 10'd500, 1'b0, 8'h00);
        tick(1'b0, 1'b0, umc_pkg::THRESH_RESET, 1'b0, 8'h00);
        tick(1'b1, 1'b1, umc_pkg::THRESH_RESET + 1'b1, 1'b0, 8'h00);
        type_line("A50", umc_pkg::CHAR_LF, 10'd600);
        tick(1'b1, 1'b1, 10'd600, 1'b0, 8'h00);
        type_line("buzzer", umc_pkg::CHAR_CR, 10'd600);
        type_line("", umc_pkg::CHAR_LF, 10'd600);
        type_line("Q9", umc_pkg::CHAR_LF, 10'd600);
        // NUL ends the command text: the trailing digit must not count
        tick(1'b1, 1'b1, 10'd600, 1'b1, umc_pkg::CHAR_B);
        tick(1'b1, 1'b1, 10'd600, 1'b1, umc_pkg::CHAR_ZERO + 8'd1);
        tick(1'b1, 1'b1, 10'd600, 1'b1, umc_pkg::CHAR_NUL);
        tick(1'b1, 1'b1, 10'd600, 1'b1, umc_pkg::CHAR_NINE);
        tick(1'b1, 1'b1, 10'd600, 1'b1, umc_pkg::CHAR_LF);
        tick(1'b1, 1'b1, 10'd600, 1'b0, 8'h00);
        finish_phase();

        // Zero period, zero threshold, zero interval
        write_register(umc_pkg::REG_PWM_PERIOD, '0);
        write_register(umc_pkg::REG_OBSTACLE, '0);
        write_register(umc_pkg::REG_TELEMETRY, '0);
        write_register(REG_UNUSED, 20'($urandom));
        type_line("S100", umc_pkg::CHAR_CR, 10'd1);
        tick(1'b1, 1'b1, 10'd1, 1'b0, 8'h00);
        tick(1'b0, 1'b1, 10'd0, 1'b0, 8'h00);
        finish_phase();

        // Full-scale period; the digit past the line capacity is dropped
        write_register(umc_pkg::REG_PWM_PERIOD, 20'hFFFFF);
        write_register(umc_pkg::REG_TELEMETRY, 20'd63);
        type_line("S0000000000000000019", umc_pkg::CHAR_LF, 10'd1023);
        tick(1'b1, 1'b1, 10'd1023, 1'b0, 8'h00);
        tick(1'b0, 1'b0, 10'd1023, 1'b0, 8'h00);
        finish_phase();

        // Everything is an obstacle
        write_register(umc_pkg::REG_PWM_PERIOD, 20'd1);
        write_register(umc_pkg::REG_OBSTACLE, 20'd1023);
        run_random(100);
        finish_phase();

        // Interval drops below the running tick count
        write_register(umc_pkg::REG_PWM_PERIOD, 20'd100);
        write_register(umc_pkg::REG_OBSTACLE, 20'd10);
        write_register(umc_pkg::REG_TELEMETRY, 20'd5);
        run_random(150);
        finish_phase();

        for (int p = 0; p < 7; p++)
        begin
            random_config();
            run_random(150);
            finish_phase();
        end

        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("[uart_motor_command_controller] OK");
        else
            $display("[uart_motor_command_controller] ERROR");
        $finish;
    end

endmodule
